### design/hmi_pkg.sv
`timescale 1ns / 1ps

package hmi_pkg;

	localparam int MAX_BINS  = 1024;
	localparam int BIN_IDX_W = $clog2(MAX_BINS);
	localparam int LOADED_W  = BIN_IDX_W + 1;
	localparam int COUNT_W   = 32;
	localparam int TOTAL_W   = COUNT_W + BIN_IDX_W;
	localparam int EDGE_W    = 32;
	localparam int WIDTH_W   = 31;
	localparam int VALUE_W   = 48;
	localparam int MBIN_W    = 10;

	// divider: numerator width*(2*inbin-1), denominator 2*count, quotient below width
	localparam int NUM_W = WIDTH_W + COUNT_W + 1;
	localparam int DEN_W = COUNT_W + 1;
	localparam int QUO_W = WIDTH_W;

	localparam int PROD_W = WIDTH_W + COUNT_W;
	localparam int BOFS_W = WIDTH_W + BIN_IDX_W;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'd1;

	localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 31'd65536;

	typedef struct packed {
		logic [COUNT_W-1:0] bin_count;
		logic               last_bin;
	} bin_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] median_value;
		logic [MBIN_W-1:0]         median_bin;
		logic                      empty_histogram;
		logic                      bins_overflowed;
	} median_result_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

### design/hmi_ram.sv
`timescale 1ns / 1ps

module hmi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/hmi_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QUO_W bits, so the top of the numerator starts below den.
module hmi_div import hmi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(QUO_W);

	logic [DEN_W-1:0]  rem_q;
	logic [QUO_W-1:0]  nlo_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	assign trial = {rem_q, nlo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NUM_W-1:QUO_W];
			nlo_q <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nlo_q <= {nlo_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### design/histogram_median_interpolated.sv
`timescale 1ns / 1ps

// Median of a uniform-bin histogram, interpolated within the median bin.
// bin_*    : one bin count per transaction; last_bin closes the histogram.
//            Bins beyond MAX_BINS are dropped and reported as overflow.
// result_* : one transaction per histogram, Q32.16 median, bin index and
//            empty / overflow flags.
// cfg_*    : index 0 left edge of bin zero (signed Q16.16), index 1 bin width
//            (unsigned Q15.16). Always ready; write only while idle.
// Throughput: bins are taken one per cycle while loading. After the last bin
// the block stops taking bins during setup, a scan that reads the bin store
// once per cycle up to the median bin, the multiply and numerator steps and a
// bit-serial divide. An empty histogram skips from setup to the result.
// The result sits in an output register, so loading of the next histogram
// starts while it waits; a second result waits until the first is taken.
// Reset clears the totals, flags and control, and sets the registers to left
// edge 0 and width 1.0. The bin store needs no clearing.
module histogram_median_interpolated import hmi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bin_valid,
	output logic                 bin_ready,
	input  bin_item_t            bin_item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output median_result_t       result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EDGE_W-1:0]    cfg_data
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_NUM   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;

	logic signed [EDGE_W-1:0] left_q;
	logic [WIDTH_W-1:0]       bw_q;

	logic [TOTAL_W-1:0]  total_q;
	logic [LOADED_W-1:0] loaded_q;
	logic                overflow_q;

	logic [TOTAL_W-1:0]   target_q;
	logic [TOTAL_W-1:0]   cum_q;
	logic [BIN_IDX_W-1:0] rd_addr_q;
	logic                 rd_vld_s1;
	logic [BIN_IDX_W-1:0] rd_idx_s1;
	logic [BIN_IDX_W-1:0] bin_q;
	logic [COUNT_W-1:0]   inbin_q;
	logic [COUNT_W-1:0]   h_q;
	logic [PROD_W-1:0]    prod_q;
	logic [BOFS_W-1:0]    bofs_q;

	median_result_t res_q;
	median_result_t result_q;
	logic           result_valid_q;

	logic               bin_acc;
	logic               full;
	logic               ram_we;
	logic               ram_re;
	logic [COUNT_W-1:0] rd_data;
	logic [TOTAL_W-1:0] scan_sum;
	logic               found;
	logic               out_free;
	logic [NUM_W-1:0]   num;
	logic [VALUE_W-1:0] value;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign bin_ready = (state_q == ST_LOAD);
	assign bin_acc   = bin_valid && bin_ready;
	assign full      = loaded_q[LOADED_W-1];
	assign ram_we    = bin_acc && !full;
	assign ram_re    = (state_q == ST_SCAN);
	assign cfg_ready = 1'b1;
	assign out_free  = !result_valid_q || result_ready;

	assign scan_sum = cum_q + {{(TOTAL_W-COUNT_W){1'b0}}, rd_data};
	assign found    = (state_q == ST_SCAN) && rd_vld_s1 && (target_q <= scan_sum);

	// 2*width*inbin - width; inbin is at least one so this never wraps
	assign num = {prod_q, 1'b0} - {{(NUM_W-WIDTH_W){1'b0}}, bw_q};

	assign div_req.start = (state_q == ST_NUM);
	assign div_req.num   = num;
	assign div_req.den   = {h_q, 1'b0};

	// all terms bounded well inside 48 bits, so no saturation is reachable
	assign value = {{(VALUE_W-EDGE_W){left_q[EDGE_W-1]}}, left_q}
		+ {{(VALUE_W-BOFS_W){1'b0}}, bofs_q}
		+ {{(VALUE_W-QUO_W){1'b0}}, div_rsp.quo};

	hmi_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_BINS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(loaded_q[BIN_IDX_W-1:0]),
		.wdata(bin_item.bin_count),
		.re   (ram_re),
		.raddr(rd_addr_q),
		.rdata(rd_data)
	);

	hmi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			bw_q   <= BIN_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEFT_EDGE: left_q <= cfg_data;
				CFG_BIN_WIDTH: bw_q   <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			total_q        <= '0;
			loaded_q       <= '0;
			overflow_q     <= 1'b0;
			rd_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && !found;
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (bin_acc) begin
						if (full) begin
							overflow_q <= 1'b1;
						end else begin
							total_q  <= total_q + {{BIN_IDX_W{1'b0}}, bin_item.bin_count};
							loaded_q <= loaded_q + 1'b1;
						end
						if (bin_item.last_bin) begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= (total_q == '0) ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					if (found) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_NUM;
				ST_NUM: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						total_q    <= '0;
						loaded_q   <= '0;
						overflow_q <= 1'b0;
						state_q    <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
		case (state_q)
			ST_SETUP: begin
				target_q  <= TOTAL_W'((total_q + 1'b1) >> 1);
				cum_q     <= '0;
				rd_addr_q <= '0;
				res_q     <= '{median_value: '0, median_bin: '0,
					empty_histogram: 1'b1, bins_overflowed: overflow_q};
			end
			ST_SCAN: begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (found) begin
					bin_q   <= rd_idx_s1;
					inbin_q <= COUNT_W'(target_q - cum_q);
					h_q     <= rd_data;
				end else if (rd_vld_s1) begin
					cum_q <= scan_sum;
				end
			end
			ST_MUL: begin
				prod_q <= bw_q * inbin_q;
				bofs_q <= bw_q * bin_q;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					res_q <= '{median_value: value, median_bin: MBIN_W'(bin_q),
						empty_histogram: 1'b0, bins_overflowed: overflow_q};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					result_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= LOADED_W'(MAX_BINS))
		else $error("bin count beyond store depth");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> ({1'b0, rd_idx_s1} < loaded_q))
		else $error("median bin found past the loaded bins");

	a_scan_hits: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> (rd_data != '0))
		else $error("median bin with zero count");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_rsp.done && bw_q != '0) |-> (div_rsp.quo < bw_q))
		else $error("interpolated term not below bin width");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.empty_histogram) |->
			(result.median_value == '0 && result.median_bin == '0))
		else $error("empty histogram with non-zero result");

endmodule
